### rtl/ntc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntc_pkg: shared definitions for the normalized tanh curve
// Widths, register codes and reset values, the stage-enable group of the tanh
// lookup, and the elaboration-time generator of the tanh table entries.
// ----------------------------------------------------------------------------
package ntc_pkg;

    localparam int unsigned TANH_TABLE_DEPTH_DEF = 256;

    localparam int unsigned SAMPLE_W = 17;
    localparam int unsigned SLOPE_W  = 24;
    localparam int unsigned CENTER_W = 20;
    localparam int unsigned GAIN_W   = 24;
    localparam int unsigned BETA_W   = 18;
    localparam int unsigned CFG_W    = 24;
    localparam int unsigned CFG_IDX_W = 2;

    localparam int unsigned DIFF_W  = 21;  // x - b, signed
    localparam int unsigned DMAG_W  = 20;  // |x - b|
    localparam int unsigned PROD_W  = 44;  // a * |x - b|, Q.32
    localparam int unsigned ARG_W   = 35;  // argument below 8.0 in Q.32
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned TANH_W  = 18;  // signed tanh, Q1.16
    localparam int unsigned QDIF_W  = 19;  // tanh - beta, signed
    localparam int unsigned QMAG_W  = 18;
    localparam int unsigned GPROD_W = 43;

    localparam logic [SAMPLE_W-1:0] Q16_ONE = 17'd65536;
    localparam logic [FRAC_W:0]     HALF_LSB = 17'd32768;

    localparam logic [SLOPE_W-1:0]         SLOPE_A_RESET    = 24'd127527;
    localparam logic signed [CENTER_W-1:0] CENTER_B_RESET   = 20'sd32768;
    localparam logic [GAIN_W-1:0]          GAIN_ALPHA_RESET = 24'd43691;
    localparam logic signed [BETA_W-1:0]   BASE_BETA_RESET  = -18'sd49152;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOPE_A    = 2'd0,
        REG_CENTER_B   = 2'd1,
        REG_GAIN_ALPHA = 2'd2,
        REG_BASE_BETA  = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic idx_en;
        logic rom_en;
        logic interp_en;
    } tanh_en_t;

    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    // Restoring division, constant arguments only.
    function automatic logic [63:0] div64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        int          i;
        rem = '0;
        quo = '0;
        for (i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // round(65536 * tanh(8k/depth)) from a truncated series of exp.
    function automatic logic [SAMPLE_W-1:0] tanh_rom_entry(input int unsigned k,
                                                           input int unsigned depth);
        logic [63:0] u;
        logic [63:0] v;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        int          n;
        u    = div64((64'(k) * 64'd16) << 30, 64'(depth));
        v    = u >> 5;
        pos  = ONE_Q30;
        neg  = '0;
        term = ONE_Q30;
        for (n = 1; n <= 10; n++)
        begin
            term = div64((term * v) >> 30, 64'(n));
            if (n % 2 == 1)
                neg = neg + term;
            else
                pos = pos + term;
        end
        e = (pos > neg) ? pos - neg : 64'd0;
        if (e > ONE_Q30)
            e = ONE_Q30;
        for (n = 0; n < 5; n++)
            e = (e * e + (ONE_Q30 >> 1)) >> 30;
        if (e > ONE_Q30)
            e = ONE_Q30;
        num = (ONE_Q30 - e) * 64'd65536 + ((ONE_Q30 + e) >> 1);
        den = ONE_Q30 + e;
        return SAMPLE_W'(div64(num, den));
    endfunction

endpackage
`default_nettype wire

### rtl/ntc_tanh.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntc_tanh: three-stage tanh lookup with linear interpolation
// Splits the Q.32 argument into table index and fraction, reads two adjacent
// table entries, interpolates and applies the sign. Saturates to one at 8.0.
// ----------------------------------------------------------------------------
module ntc_tanh #(
    parameter int unsigned TABLE_DEPTH = ntc_pkg::TANH_TABLE_DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire ntc_pkg::tanh_en_t                  en,
    input  wire logic [ntc_pkg::PROD_W-1:0]         arg,
    input  wire logic                               arg_neg,
    output logic signed [ntc_pkg::TANH_W-1:0]       tanh_val
);
    import ntc_pkg::*;

    localparam int unsigned IW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned PW = ARG_W + IW;

    logic [SAMPLE_W-1:0] rom [0:TABLE_DEPTH];

    for (genvar k = 0; k <= TABLE_DEPTH; k++)
    begin : g_rom
        localparam logic [SAMPLE_W-1:0] ENTRY = tanh_rom_entry(k, TABLE_DEPTH);
        assign rom[k] = ENTRY;
    end

    logic [PW-1:0]       pos_scaled;
    logic [IW-1:0]       idx_reg;
    logic [FRAC_W-1:0]   frac_reg;
    logic                sat_reg;
    logic                neg_reg;

    logic [IW-1:0]       idx_hi;
    logic [SAMPLE_W-1:0] r0_reg;
    logic [SAMPLE_W-1:0] r1_reg;
    logic [FRAC_W-1:0]   frac_rom_reg;
    logic                sat_rom_reg;
    logic                neg_rom_reg;

    logic [SAMPLE_W-1:0] diff;
    logic [32:0]         interp;
    logic [SAMPLE_W:0]   th;
    logic [SAMPLE_W-1:0] th_mag;

    assign pos_scaled = PW'(arg[ARG_W-1:0]) * PW'(TABLE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (en.idx_en)
        begin
            idx_reg  <= pos_scaled[PW-1:ARG_W];
            frac_reg <= pos_scaled[ARG_W-1:ARG_W-FRAC_W];
            sat_reg  <= |arg[PROD_W-1:ARG_W];
            neg_reg  <= arg_neg;
        end
    end

    assign idx_hi = idx_reg + IW'(1);

    always_ff @(posedge clk)
    begin
        if (en.rom_en)
        begin
            r0_reg       <= rom[idx_reg];
            r1_reg       <= rom[idx_hi];
            frac_rom_reg <= frac_reg;
            sat_rom_reg  <= sat_reg;
            neg_rom_reg  <= neg_reg;
        end
    end

    always_comb
    begin
        diff   = (r1_reg >= r0_reg) ? r1_reg - r0_reg : '0;
        interp = 33'(diff) * 33'(frac_rom_reg) + 33'(HALF_LSB);
        th     = {1'b0, r0_reg} + {1'b0, interp[32:16]};
        th_mag = sat_rom_reg ? Q16_ONE : th[SAMPLE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.interp_en)
        begin
            if (neg_rom_reg)
                tanh_val <= -$signed({1'b0, th_mag});
            else
                tanh_val <= $signed({1'b0, th_mag});
        end
    end

endmodule
`default_nettype wire

### rtl/normalized_tanh_curve.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// normalized_tanh_curve: y = alpha * (tanh(a * (x - b)) - beta), saturated
// Eight-stage pipeline: offset, slope multiply, index split, table read,
// interpolation, base subtract, gain multiply, round and clamp.
//
//   channel  valid      stall      payload
//   src      src_valid  src_stall  sample_in
//   dst      dst_valid  dst_stall  sample_out
//   cfg      cfg_we     -          cfg_index, cfg_data
//
// One transaction per cycle while dst_stall is low.
// Reset clears all stage valid bits and loads the default curve registers.
// A stage holds only while it is full and the stage after it holds, so
// bubbles close up under dst_stall; src_stall rises when stage one is held.
// ----------------------------------------------------------------------------
module normalized_tanh_curve #(
    parameter int unsigned TABLE_DEPTH = ntc_pkg::TANH_TABLE_DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             src_valid,
    output logic                                  src_stall,
    input  wire logic [ntc_pkg::SAMPLE_W-1:0]     sample_in,
    output logic                                  dst_valid,
    input  wire logic                             dst_stall,
    output logic [ntc_pkg::SAMPLE_W-1:0]          sample_out,
    input  wire logic                             cfg_we,
    input  wire logic [ntc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ntc_pkg::CFG_W-1:0]        cfg_data
);
    import ntc_pkg::*;

    localparam int unsigned STAGES = 8;

    logic [SLOPE_W-1:0]         slope_a_reg;
    logic signed [CENTER_W-1:0] center_b_reg;
    logic [GAIN_W-1:0]          gain_alpha_reg;
    logic signed [BETA_W-1:0]   base_beta_reg;

    logic [STAGES:1] valid_reg;
    logic [STAGES:1] valid_next;
    logic [STAGES:1] load;

    logic signed [DIFF_W-1:0]   diff;
    logic [DMAG_W-1:0]          dmag_reg;
    logic                       neg1_reg;
    logic [PROD_W-1:0]          arg_reg;
    logic                       neg2_reg;
    tanh_en_t                   tanh_en;
    logic signed [TANH_W-1:0]   tanh_val;
    logic signed [QDIF_W-1:0]   qdif;
    logic [QMAG_W-1:0]          qmag_reg;
    logic                       qpos6_reg;
    logic [GPROD_W-1:0]         gprod_reg;
    logic                       qpos7_reg;
    logic [GPROD_W-FRAC_W-1:0]  y;
    logic [SAMPLE_W-1:0]        sample_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_a_reg    <= SLOPE_A_RESET;
            center_b_reg   <= CENTER_B_RESET;
            gain_alpha_reg <= GAIN_ALPHA_RESET;
            base_beta_reg  <= BASE_BETA_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_SLOPE_A:    slope_a_reg    <= cfg_data[SLOPE_W-1:0];
                REG_CENTER_B:   center_b_reg   <= $signed(cfg_data[CENTER_W-1:0]);
                REG_GAIN_ALPHA: gain_alpha_reg <= cfg_data[GAIN_W-1:0];
                REG_BASE_BETA:  base_beta_reg  <= $signed(cfg_data[BETA_W-1:0]);
            endcase
        end
    end

    // advance a stage when it is empty or its successor advances
    always_comb
    begin
        load[STAGES] = !valid_reg[STAGES] || !dst_stall;
        for (int s = STAGES - 1; s >= 1; s--)
            load[s] = !valid_reg[s] || load[s+1];
        valid_next = valid_reg;
        if (load[1])
            valid_next[1] = src_valid;
        for (int s = 2; s <= STAGES; s++)
        begin
            if (load[s])
                valid_next[s] = valid_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign src_stall = !load[1];
    assign dst_valid = valid_reg[STAGES];

    assign diff = $signed({4'b0000, sample_in}) - {center_b_reg[CENTER_W-1], center_b_reg};

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            neg1_reg <= diff[DIFF_W-1];
            dmag_reg <= diff[DIFF_W-1] ? DMAG_W'(-diff) : DMAG_W'(diff);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            arg_reg  <= PROD_W'(slope_a_reg) * PROD_W'(dmag_reg);
            neg2_reg <= neg1_reg;
        end
    end

    assign tanh_en.idx_en    = load[3];
    assign tanh_en.rom_en    = load[4];
    assign tanh_en.interp_en = load[5];

    ntc_tanh #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_tanh (
        .clk      (clk),
        .en       (tanh_en),
        .arg      (arg_reg),
        .arg_neg  (neg2_reg),
        .tanh_val (tanh_val)
    );

    assign qdif = QDIF_W'(tanh_val) - QDIF_W'(base_beta_reg);

    always_ff @(posedge clk)
    begin
        if (load[6])
        begin
            qpos6_reg <= !qdif[QDIF_W-1] && (qdif != '0);
            qmag_reg  <= qdif[QMAG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[7])
        begin
            gprod_reg <= GPROD_W'(gain_alpha_reg) * GPROD_W'(qmag_reg) + GPROD_W'(HALF_LSB);
            qpos7_reg <= qpos6_reg;
        end
    end

    assign y = gprod_reg[GPROD_W-1:FRAC_W];

    always_ff @(posedge clk)
    begin
        if (load[8])
        begin
            priority if (!qpos7_reg)
                sample_out_reg <= '0;
            else if (y > (GPROD_W-FRAC_W)'(Q16_ONE))
                sample_out_reg <= Q16_ONE;
            else
                sample_out_reg <= y[SAMPLE_W-1:0];
        end
    end

    assign sample_out = sample_out_reg;

endmodule
`default_nettype wire
